FILE: design/base64_stream_decoder_core_assert.svh
// assertion macros for the base64 stream decoder core
// no dependencies; included by the top level only
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64D_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64d assertion failed");

// next-cycle implication, checked outside reset
`define B64D_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64d assertion failed");

`endif

FILE: design/b64d_pkg.sv
// shared types and constants for the base64 stream decoder
// no dependencies
`default_nettype none

package b64d_pkg;

   // length and counter widths
   localparam int LENGTH_WIDTH = 16;
   localparam int COUNT_WIDTH  = LENGTH_WIDTH + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_URL_MODE = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;
   localparam logic [LENGTH_WIDTH-1:0] CAPACITY_RESET = '1;

   // end-of-message status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_CAPACITY  = 2'd2;

   // input beat
   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0]              data_byte;
      logic                    byte_valid;
      logic                    end_of_message;
      logic [1:0]              status;
      logic [LENGTH_WIDTH-1:0] decoded_length;
   } rsp_type;

   // classified character, front to back
   typedef struct packed {
      logic [5:0] sym;
      logic       is_pad;
      logic       bad;
      logic       last;
      logic       url;
   } entry_type;

endpackage

`default_nettype wire

FILE: design/b64d_front.sv
// front part: accepts characters, classifies them, and queues them
// depends on b64d_pkg
`default_nettype none

module b64d_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                url_mode,
   input  wire logic                push,
   input  wire b64d_pkg::req_type   req_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output b64d_pkg::entry_type      head
);

   localparam logic [7:0] CHAR_PAD        = 8'd61;
   localparam logic [7:0] CHAR_PLUS       = 8'd43;
   localparam logic [7:0] CHAR_SLASH      = 8'd47;
   localparam logic [7:0] CHAR_MINUS      = 8'd45;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;

   b64d_pkg::entry_type               entry;
   b64d_pkg::entry_type               mem_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::QCNT_WIDTH-1:0]   count_ff, count_in;

   // map a character to its 6-bit symbol, pad or bad flag
   always_comb begin
      entry.sym    = 6'd0;
      entry.is_pad = 1'b0;
      entry.bad    = 1'b0;
      entry.last   = req_data.last_char;
      entry.url    = url_mode;
      if (req_data.character inside {[8'd65:8'd90]}) begin
         entry.sym = 6'(req_data.character - 8'd65);
      end else if (req_data.character inside {[8'd97:8'd122]}) begin
         entry.sym = 6'(req_data.character - 8'd71);
      end else if (req_data.character inside {[8'd48:8'd57]}) begin
         entry.sym = 6'(req_data.character + 8'd4);
      end else if (url_mode && req_data.character == CHAR_MINUS) begin
         entry.sym = 6'd62;
      end else if (url_mode && req_data.character == CHAR_UNDERSCORE) begin
         entry.sym = 6'd63;
      end else if (!url_mode && req_data.character == CHAR_PLUS) begin
         entry.sym = 6'd62;
      end else if (!url_mode && req_data.character == CHAR_SLASH) begin
         entry.sym = 6'd63;
      end else if (!url_mode && req_data.character == CHAR_PAD) begin
         entry.is_pad = 1'b1;
      end else begin
         entry.bad = 1'b1;
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + b64d_pkg::QPTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + b64d_pkg::QPTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + b64d_pkg::QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - b64d_pkg::QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign full       = (count_ff == b64d_pkg::QCNT_WIDTH'(b64d_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: design/b64d_back.sv
// back part: group decoding, counting, status, and the result register
// depends on b64d_pkg
`default_nettype none

module b64d_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [b64d_pkg::LENGTH_WIDTH-1:0]     capacity,
   input  wire logic                                  head_valid,
   input  wire b64d_pkg::entry_type                   head,
   output logic                                       pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output b64d_pkg::rsp_type                          rsp_data
);

   localparam int LW = b64d_pkg::LENGTH_WIDTH;
   localparam int CW = b64d_pkg::COUNT_WIDTH;

   logic [1:0]    gpos_ff, gpos_in;
   logic [5:0]    carry_ff, carry_in;
   logic [1:0]    pad_run_ff, pad_run_in;
   logic          bad_seen_ff, bad_seen_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   b64d_pkg::rsp_type rsp_ff, rsp_in;

   logic          out_free;
   logic [7:0]    byte_val;
   logic          has_pos;
   logic          emit;
   logic [1:0]    gpos_next;
   logic [1:0]    pad_next;
   logic          bad_next;
   logic [CW-1:0] count_next;
   logic [CW-1:0] len;
   logic          form_err;
   logic [1:0]    status;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;

   // pad tracking and bad-character flag
   always_comb begin
      pad_next = pad_run_ff;
      bad_next = bad_seen_ff | head.bad;
      if (head.is_pad) begin
         if (pad_run_ff != 2'd3) begin
            pad_next = pad_run_ff + 2'd1;
         end
      end else begin
         if (pad_run_ff != 2'd0) begin
            bad_next = 1'b1;
         end
         pad_next = 2'd0;
      end
   end

   // merge the symbol with the carried bits
   always_comb begin
      byte_val = 8'd0;
      carry_in = 6'd0;
      has_pos  = 1'b1;
      case (gpos_ff)
         2'd0: begin
            carry_in = head.sym;
            has_pos  = 1'b0;
         end
         2'd1: begin
            byte_val = {carry_ff, head.sym[5:4]};
            carry_in = {2'b00, head.sym[3:0]};
         end
         2'd2: begin
            byte_val = {carry_ff[3:0], head.sym[5:2]};
            carry_in = {4'b0000, head.sym[1:0]};
         end
         default: begin
            byte_val = {carry_ff[1:0], head.sym};
         end
      endcase
   end

   assign gpos_next = gpos_ff + 2'd1;
   assign emit      = has_pos && !head.is_pad && (count_ff < {1'b0, capacity});

   // byte position count, saturating at 2^LW
   always_comb begin
      count_next = count_ff;
      if (has_pos && !count_ff[LW]) begin
         count_next = count_ff + CW'(1);
      end
   end

   // end-of-message length and status
   always_comb begin
      if (count_next < CW'(pad_next)) begin
         len = '0;
      end else begin
         len = count_next - CW'(pad_next);
      end
      if (head.url) begin
         form_err = (gpos_next == 2'd1);
      end else begin
         form_err = (gpos_next != 2'd0) || (pad_next == 2'd3);
      end
      if (form_err) begin
         status = b64d_pkg::STATUS_MALFORMED;
      end else if (len > {1'b0, capacity}) begin
         status = b64d_pkg::STATUS_CAPACITY;
      end else if (bad_next) begin
         status = b64d_pkg::STATUS_MALFORMED;
      end else begin
         status = b64d_pkg::STATUS_OK;
      end
   end

   // next message state, cleared after the last character
   always_comb begin
      gpos_in     = gpos_ff;
      pad_run_in  = pad_run_ff;
      bad_seen_in = bad_seen_ff;
      count_in    = count_ff;
      if (pop) begin
         if (head.last) begin
            gpos_in     = 2'd0;
            pad_run_in  = 2'd0;
            bad_seen_in = 1'b0;
            count_in    = '0;
         end else begin
            gpos_in     = gpos_next;
            pad_run_in  = pad_next;
            bad_seen_in = bad_next;
            count_in    = count_next;
         end
      end
   end

   // result beat
   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = pop && (emit || head.last);
      end
      if (pop) begin
         rsp_in.data_byte      = emit ? byte_val : 8'd0;
         rsp_in.byte_valid     = emit;
         rsp_in.end_of_message = head.last;
         rsp_in.status         = head.last ? status : b64d_pkg::STATUS_OK;
         rsp_in.decoded_length = '0;
         if (head.last) begin
            rsp_in.decoded_length = len[LW] ? {LW{1'b1}} : len[LW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpos_ff      <= 2'd0;
         carry_ff     <= 6'd0;
         pad_run_ff   <= 2'd0;
         bad_seen_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gpos_ff      <= gpos_in;
         pad_run_ff   <= pad_run_in;
         bad_seen_ff  <= bad_seen_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            carry_ff <= head.last ? 6'd0 : carry_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: design/base64_stream_decoder_core.sv
// Base64 / Base64URL stream decoder, one character per beat.
//
// Channels: req_ carries one character and a last flag per beat; rsp_ carries
// a decoded byte, or the end-of-message report (status, decoded length), or
// both. Characters that complete no byte and are not last give no rsp beat.
// csr_ is an APB-style port: url_mode at 0x0, output_capacity at 0x4.
// An accepted character is written into the queue, then decoded into the
// result register. Throughput: one character per clock while rsp_stall is low,
// set by the single back stage that updates the group state once per character.
// A four-entry queue sits between the classifying front and the decoding
// back. When rsp_stall is high while a result is pending, the result register
// holds, the queue fills, and req_stall rises once the queue is full.
// Reset: url_mode 0, output_capacity 65535, queue empty, message state clear,
// no result pending. The user writes registers only while the block is idle;
// the block does not enforce this. Status: 0 ok, 1 malformed, 2 capacity
// exceeded; bytes sent before a failing status are not withdrawn.
// depends on b64d_pkg, b64d_front, b64d_back
`default_nettype none
`include "base64_stream_decoder_core_assert.svh"

module base64_stream_decoder_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire b64d_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output b64d_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [b64d_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [b64d_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [b64d_pkg::CSR_DATA_WIDTH-1:0]         csr_prdata,
   output logic                                        csr_pready
);

   localparam int LW = b64d_pkg::LENGTH_WIDTH;
   localparam int DW = b64d_pkg::CSR_DATA_WIDTH;

   logic                       url_mode_ff, url_mode_in;
   logic [LW-1:0]              capacity_ff, capacity_in;
   logic                       csr_write;
   logic                       push;
   logic                       full;
   logic                       pop;
   logic                       head_valid;
   b64d_pkg::entry_type        head;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      url_mode_in = url_mode_ff;
      capacity_in = capacity_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            b64d_pkg::REG_URL_MODE: url_mode_in = csr_pwdata[0];
            b64d_pkg::REG_CAPACITY: capacity_in = csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         url_mode_ff <= 1'b0;
         capacity_ff <= b64d_pkg::CAPACITY_RESET;
      end else begin
         url_mode_ff <= url_mode_in;
         capacity_ff <= capacity_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[2])
         b64d_pkg::REG_URL_MODE: csr_prdata = {{(DW-1){1'b0}}, url_mode_ff};
         b64d_pkg::REG_CAPACITY: csr_prdata = DW'(capacity_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // input beat handshake
   assign req_stall = full;
   assign push      = req_valid && !full;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .url_mode   (url_mode_ff),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // a beat without an end report always carries a byte
   `B64D_ASSERT_IMP(a_mid_beat_has_byte, clock, reset,
      rsp_valid && !rsp_data.end_of_message, rsp_data.byte_valid)
   // status and length are reported only at the end of a message
   `B64D_ASSERT_IMP(a_report_only_at_end, clock, reset,
      rsp_valid && !rsp_data.end_of_message,
      rsp_data.status == b64d_pkg::STATUS_OK && rsp_data.decoded_length == '0)
   // status is always a defined code
   `B64D_ASSERT_IMP(a_status_code, clock, reset, rsp_valid,
      rsp_data.status == b64d_pkg::STATUS_OK ||
      rsp_data.status == b64d_pkg::STATUS_MALFORMED ||
      rsp_data.status == b64d_pkg::STATUS_CAPACITY)
   // nothing is popped from the queue while the result register is stalled
   `B64D_ASSERT_IMP(a_no_pop_when_stalled, clock, reset,
      rsp_valid && rsp_stall, !pop)

endmodule

`default_nettype wire
